// File: sv/dmt_pkg.sv
// Shared types and constants for the display mode table.
`timescale 1ns / 1ps

package dmt_pkg;

  // Opcodes.
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_LOOKUP  = 2'd1;
  localparam logic [1:0] OP_NEAREST = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_FILTERED  = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_HEIGHT    = 3'd3;
  localparam logic [2:0] ST_DUPLICATE = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEPTH_FILTER = 2'd0;
  localparam logic [1:0] CFG_MAX_WIDTH    = 2'd1;
  localparam logic [1:0] CFG_MAX_HEIGHT   = 2'd2;

  // Heights must be a multiple of 8.
  localparam logic [2:0] HEIGHT_ALIGN_MASK = 3'd7;

  localparam logic [5:0]  DEPTH_FILTER_RST = 6'd0;
  localparam logic [15:0] MAX_WIDTH_RST    = 16'hFFFF;
  localparam logic [15:0] MAX_HEIGHT_RST   = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] in_width;
    logic [15:0] in_height;
    logic [5:0]  in_depth;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [15:0] out_width;
    logic [15:0] out_height;
  } out_item_t;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] h;
    logic [5:0]  d;
  } mode_entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic start;
    logic rd_en;
    logic load;
  } dmt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_end;
    logic pipe_busy;
    logic out_free;
  } dmt_sts_t;

endpackage

// File: sv/display_mode_table_nearest_match.sv
// Top level of the display mode table with exact lookup and nearest search.
`timescale 1ns / 1ps

// Keeps up to TABLE_DEPTH display modes in insertion order and serves one
// operation per input beat: insert, exact lookup, nearest search or clear.
// Each beat runs a scan that reads one stored entry per cycle from the
// entry memory, plus the read, square and compare stages, before the result
// register is loaded. A clear, or any operation on an empty table, skips the
// scan. One beat is in flight at a time; the next is accepted while a
// result still waits in the output register. Configuration writes must be
// made only while idle; the block itself does not enforce this.

module display_mode_table_nearest_match
  import dmt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  dmt_cmd_t cmd;
  dmt_sts_t sts;

  dmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dmt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: sv/dmt_ctrl.sv
// Controller state machine for the display mode table.
`timescale 1ns / 1ps

module dmt_ctrl
  import dmt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dmt_sts_t sts,
  output dmt_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = S_DRAIN;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/dmt_dp.sv
// Datapath for the display mode table: entry memory, scan pipeline and result register.
`timescale 1ns / 1ps

module dmt_dp
  import dmt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_wdata,
  input  dmt_cmd_t  cmd,
  output dmt_sts_t  sts,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Configuration registers.
  logic [5:0]  depth_filter_r;
  logic [15:0] max_width_r;
  logic [15:0] max_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_filter_r <= DEPTH_FILTER_RST;
      max_width_r    <= MAX_WIDTH_RST;
      max_height_r   <= MAX_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEPTH_FILTER: depth_filter_r <= cfg_wdata[5:0];
        CFG_MAX_WIDTH:    max_width_r    <= cfg_wdata;
        CFG_MAX_HEIGHT:   max_height_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Current item.
  in_item_t item_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item_r <= in_data;
    end
  end

  // Entry memory with registered read.
  mode_entry_t mem [TABLE_DEPTH];
  mode_entry_t rd_q_r;
  logic [CNT_W-1:0] addr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             mem_we;
  mode_entry_t      wr_entry;

  assign wr_entry = '{w: item_r.in_width, h: item_r.in_height, d: item_r.in_depth};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= wr_entry;
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem[addr_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      addr_r <= '0;
    end else if (cmd.rd_en) begin
      addr_r <= addr_r + CNT_W'(1);
    end
  end

  assign sts.scan_end = (addr_r == count_r) || (item_r.opcode == OP_CLEAR);

  // Stage 2: distance terms and match flags.
  logic        v1_r;
  logic        v2_r;
  logic [15:0] dw;
  logic [15:0] dh;
  logic [31:0] sqw_r;
  logic [31:0] sqh_r;
  logic        dm2_r;
  logic        hit2_r;
  logic [15:0] w2_r;
  logic [15:0] h2_r;

  assign dw = (rd_q_r.w >= item_r.in_width)  ? rd_q_r.w - item_r.in_width
                                              : item_r.in_width - rd_q_r.w;
  assign dh = (rd_q_r.h >= item_r.in_height) ? rd_q_r.h - item_r.in_height
                                              : item_r.in_height - rd_q_r.h;

  always_ff @(posedge clk) begin
    sqw_r  <= 32'(dw) * 32'(dw);
    sqh_r  <= 32'(dh) * 32'(dh);
    dm2_r  <= (rd_q_r.d == item_r.in_depth);
    hit2_r <= (rd_q_r.d == item_r.in_depth) && (rd_q_r.w == item_r.in_width) &&
              (rd_q_r.h == item_r.in_height);
    w2_r   <= rd_q_r.w;
    h2_r   <= rd_q_r.h;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
    end
  end

  assign sts.pipe_busy = v1_r | v2_r;

  // Stage 3: running best and exact hit. A strict compare keeps the earliest entry on ties.
  logic [32:0] score;
  logic [32:0] best_r;
  logic        have_r;
  logic        hit_r;
  logic [15:0] bw_r;
  logic [15:0] bh_r;

  assign score = {1'b0, sqw_r} + {1'b0, sqh_r};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      have_r <= 1'b0;
      hit_r  <= 1'b0;
    end else if (v2_r) begin
      if (hit2_r) begin
        hit_r <= 1'b1;
      end
      if (dm2_r && (!have_r || score < best_r)) begin
        have_r <= 1'b1;
        best_r <= score;
        bw_r   <= w2_r;
        bh_r   <= h2_r;
      end
    end
  end

  // Result.
  logic [2:0] ins_status;
  out_item_t  res;

  always_comb begin
    priority if (depth_filter_r != '0 && item_r.in_depth != depth_filter_r) begin
      ins_status = ST_FILTERED;
    end else if (item_r.in_width > max_width_r || item_r.in_height > max_height_r) begin
      ins_status = ST_TOO_LARGE;
    end else if ((item_r.in_height[2:0] & HEIGHT_ALIGN_MASK) != '0) begin
      ins_status = ST_HEIGHT;
    end else if (hit_r) begin
      ins_status = ST_DUPLICATE;
    end else if (count_r >= CNT_W'(TABLE_DEPTH)) begin
      ins_status = ST_FULL;
    end else begin
      ins_status = ST_DONE;
    end
  end

  always_comb begin
    res.status     = ST_DONE;
    res.found      = 1'b0;
    res.out_width  = item_r.in_width;
    res.out_height = item_r.in_height;
    count_nxt      = count_r;
    mem_we         = 1'b0;
    unique case (item_r.opcode)
      OP_INSERT: begin
        res.status = ins_status;
        if (cmd.load && ins_status == ST_DONE) begin
          mem_we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_LOOKUP: begin
        res.found = hit_r;
      end
      OP_NEAREST: begin
        res.found = have_r;
        if (have_r) begin
          res.out_width  = bw_r;
          res.out_height = bh_r;
        end
      end
      OP_CLEAR: begin
        if (cmd.load) begin
          count_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Output register.
  logic      out_valid_r;
  out_item_t out_data_r;

  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the display mode table with nearest-mode search.
`timescale 1ns / 1ps

class mode_table_scoreboard;
  localparam int DEPTH = 64;

  dmt_pkg::mode_entry_t entries[DEPTH];
  int unsigned          count;
  logic [5:0]           depth_filter;
  logic [15:0]          max_w;
  logic [15:0]          max_h;
  dmt_pkg::out_item_t   expected_q[$];
  int unsigned          n_accepted;
  int unsigned          n_errors;

  function new();
    count        = 0;
    depth_filter = dmt_pkg::DEPTH_FILTER_RST;
    max_w        = dmt_pkg::MAX_WIDTH_RST;
    max_h        = dmt_pkg::MAX_HEIGHT_RST;
    n_accepted   = 0;
    n_errors     = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      dmt_pkg::CFG_DEPTH_FILTER: depth_filter = val[5:0];
      dmt_pkg::CFG_MAX_WIDTH:    max_w = val;
      dmt_pkg::CFG_MAX_HEIGHT:   max_h = val;
      default: ;
    endcase
  endfunction

  function bit holds(logic [15:0] w, logic [15:0] h, logic [5:0] d);
    for (int i = 0; i < count; i++) begin
      if (entries[i].w == w && entries[i].h == h && entries[i].d == d) return 1'b1;
    end
    return 1'b0;
  endfunction

  function void note_input(dmt_pkg::in_item_t it);
    dmt_pkg::out_item_t exp;
    longint unsigned    best;
    longint unsigned    score;
    longint unsigned    dw;
    longint unsigned    dh;
    bit                 have;
    exp.status     = dmt_pkg::ST_DONE;
    exp.found      = 1'b0;
    exp.out_width  = it.in_width;
    exp.out_height = it.in_height;
    n_accepted++;
    case (it.opcode)
      dmt_pkg::OP_INSERT: begin
        // The first failing check decides the status.
        if (depth_filter != 0 && it.in_depth != depth_filter) begin
          exp.status = dmt_pkg::ST_FILTERED;
        end else if (it.in_width > max_w || it.in_height > max_h) begin
          exp.status = dmt_pkg::ST_TOO_LARGE;
        end else if ((it.in_height & dmt_pkg::HEIGHT_ALIGN_MASK) != 0) begin
          exp.status = dmt_pkg::ST_HEIGHT;
        end else if (holds(it.in_width, it.in_height, it.in_depth)) begin
          exp.status = dmt_pkg::ST_DUPLICATE;
        end else if (count >= DEPTH) begin
          exp.status = dmt_pkg::ST_FULL;
        end else begin
          entries[count].w = it.in_width;
          entries[count].h = it.in_height;
          entries[count].d = it.in_depth;
          count++;
        end
      end
      dmt_pkg::OP_LOOKUP: exp.found = holds(it.in_width, it.in_height, it.in_depth);
      dmt_pkg::OP_NEAREST: begin
        have = 1'b0;
        best = 0;
        for (int i = 0; i < count; i++) begin
          if (entries[i].d != it.in_depth) continue;
          dw = (entries[i].w >= it.in_width) ? entries[i].w - it.in_width
                                             : it.in_width - entries[i].w;
          dh = (entries[i].h >= it.in_height) ? entries[i].h - it.in_height
                                              : it.in_height - entries[i].h;
          score = dw * dw + dh * dh;
          // Strictly less, so the earliest stored entry keeps a tie.
          if (!have || score < best) begin
            have           = 1'b1;
            best           = score;
            exp.found      = 1'b1;
            exp.out_width  = entries[i].w;
            exp.out_height = entries[i].h;
          end
        end
      end
      default: count = 0;
    endcase
    expected_q = {expected_q, exp};
  endfunction

  function void check_result(dmt_pkg::out_item_t got);
    dmt_pkg::out_item_t exp;
    if (expected_q.size() == 0) begin
      n_errors++;
      $display("%0t: unexpected result beat: expected none, actual %h", $time, got);
      return;
    end
    exp = expected_q.pop_front();
    if (got.status !== exp.status) begin
      n_errors++;
      $display("%0t: status mismatch: expected %0d, actual %0d",
               $time, exp.status, got.status);
    end
    if (got.found !== exp.found) begin
      n_errors++;
      $display("%0t: found mismatch: expected %0d, actual %0d",
               $time, exp.found, got.found);
    end
    if (got.out_width !== exp.out_width) begin
      n_errors++;
      $display("%0t: width mismatch: expected %0d, actual %0d",
               $time, exp.out_width, got.out_width);
    end
    if (got.out_height !== exp.out_height) begin
      n_errors++;
      $display("%0t: height mismatch: expected %0d, actual %0d",
               $time, exp.out_height, got.out_height);
    end
  endfunction
endclass

module testbench;
  import dmt_pkg::*;

  localparam int          TABLE_DEPTH  = 64;
  localparam int          LIMIT_CYCLES = 1000000;
  localparam int          HOLD_CYCLES  = 400;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  mode_table_scoreboard sb;
  int unsigned          n_sent;
  int unsigned          cycle_count;
  int unsigned          send_idle_pct;
  int unsigned          recv_idle_pct;
  bit                   hold_req;

  display_mode_table_nearest_match #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Watch both channels; values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic in_item_t mk(logic [1:0] op, logic [15:0] w, logic [15:0] h,
                                  logic [5:0] d);
    in_item_t it;
    it.opcode    = op;
    it.in_width  = w;
    it.in_height = h;
    it.in_depth  = d;
    return it;
  endfunction

  // An insert that passes the filter and size checks under the current registers.
  function automatic in_item_t good_insert();
    logic [5:0]  d;
    int unsigned wl;
    int unsigned hl;
    d  = (sb.depth_filter != 0) ? sb.depth_filter : 6'(8 * $urandom_range(4, 1));
    wl = sb.max_w;
    hl = sb.max_h;
    if ($urandom_range(1)) begin
      if (wl > 2047) wl = 2047;
      if (hl > 2047) hl = 2047;
    end
    return mk(OP_INSERT, 16'($urandom_range(wl, 0)), 16'(8 * $urandom_range(hl / 8, 0)), d);
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned k;
    mode_entry_t e;
    if ($urandom_range(99) < 20) begin
      it = in_item_t'(40'({$urandom, $urandom}));
      return it;
    end
    k = $urandom_range(99);
    if (sb.count > 0) e = sb.entries[$urandom_range(sb.count - 1, 0)];
    if (k < 10 && sb.count > 0) begin
      it = mk(OP_INSERT, e.w, e.h, e.d);
    end else if (k < 40) begin
      it = good_insert();
    end else if (k < 46) begin
      // Broken insert: misaligned height or one pixel over a limit.
      it = good_insert();
      if ($urandom_range(1)) it.in_height = it.in_height | 16'($urandom_range(7, 1));
      else if (sb.max_w != 16'hFFFF) it.in_width = sb.max_w + 16'd1;
      else it.in_height = sb.max_h + 16'd1;
    end else if (k < 62) begin
      if (sb.count > 0 && $urandom_range(1)) it = mk(OP_LOOKUP, e.w, e.h, e.d);
      else it = good_insert();
      it.opcode = OP_LOOKUP;
    end else if (k < 99) begin
      it = mk(OP_NEAREST, 16'($urandom_range(2047, 0)), 16'($urandom_range(2047, 0)),
              6'(8 * $urandom_range(4, 1)));
      if ($urandom_range(3) == 0) it.in_width = 16'($urandom);
      if ($urandom_range(3) == 0) it.in_height = 16'($urandom);
      if (sb.count > 0 && $urandom_range(1)) it.in_depth = e.d;
    end else begin
      it = mk(OP_CLEAR, 16'($urandom), 16'($urandom), 6'($urandom));
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  // Returns on a rising edge once every beat sent has produced its result.
  task automatic drain();
    in_valid <= 1'b0;
    while (n_sent != sb.n_accepted || sb.expected_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_regs(input logic [5:0] df, input logic [15:0] mw,
                            input logic [15:0] mh);
    logic [15:0] vals[4];
    vals[0] = {10'($urandom), df};
    vals[1] = mw;
    vals[2] = mh;
    vals[3] = 16'($urandom);
    cfg_we <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= 2'(i);
      cfg_wdata <= vals[i];
      sb.write_reg(2'(i), vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [5:0] df, input logic [15:0] mw, input logic [15:0] mh,
                           input int unsigned sidle, input int unsigned ridle,
                           input bit hold, input int unsigned n_items);
    drain();
    write_regs(df, mw, mh);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    if (hold) hold_req = 1'b1;
    send_item(mk(OP_CLEAR, 16'hFFFF, 16'h0000, 6'h3F));
    // Fill past the table size so the full case comes up.
    repeat (TABLE_DEPTH + 6) send_item(good_insert());
    repeat (n_items - TABLE_DEPTH - 7) send_item(random_item());
  endtask

  initial begin
    sb            = new();
    n_sent        = 0;
    cycle_count   = 0;
    send_idle_pct = 30;
    recv_idle_pct = 54;
    hold_req      = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_DEPTH_FILTER;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset register values.
    send_item(mk(OP_INSERT, 16'd640, 16'd480, 6'd8));
    send_item(mk(OP_INSERT, 16'd640, 16'd480, 6'd8));
    send_item(mk(OP_INSERT, 16'hFFFF, 16'hFFF8, 6'd32));
    send_item(mk(OP_INSERT, 16'd0, 16'd0, 6'd0));
    send_item(mk(OP_INSERT, 16'd800, 16'd601, 6'd16));
    send_item(mk(OP_INSERT, 16'd800, 16'd480, 6'd8));
    send_item(mk(OP_LOOKUP, 16'd640, 16'd480, 6'd8));
    send_item(mk(OP_LOOKUP, 16'd640, 16'd480, 6'd16));
    send_item(mk(OP_NEAREST, 16'd700, 16'd500, 6'd8));
    // Equal distance to both stored 8-bit modes: the earlier one wins.
    send_item(mk(OP_NEAREST, 16'd720, 16'd480, 6'd8));
    send_item(mk(OP_NEAREST, 16'd100, 16'd100, 6'd24));
    send_item(mk(OP_NEAREST, 16'hFFFF, 16'hFFFF, 6'h3F));
    send_item(mk(OP_NEAREST, 16'd5, 16'd5, 6'd0));
    send_item(mk(OP_NEAREST, 16'd0, 16'd0, 6'd32));
    send_item(mk(OP_CLEAR, 16'd1, 16'd2, 6'd3));
    send_item(mk(OP_LOOKUP, 16'd640, 16'd480, 6'd8));

    drain();
    write_regs(6'd32, 16'd1920, 16'd1080);
    send_item(mk(OP_INSERT, 16'd640, 16'd480, 6'd8));
    send_item(mk(OP_INSERT, 16'd2560, 16'd1440, 6'd32));
    send_item(mk(OP_INSERT, 16'd1921, 16'd1080, 6'd32));
    send_item(mk(OP_INSERT, 16'd1920, 16'd1088, 6'd32));
    send_item(mk(OP_INSERT, 16'd2000, 16'd1001, 6'd32));
    send_item(mk(OP_INSERT, 16'd1920, 16'd1080, 6'd32));
    send_item(mk(OP_NEAREST, 16'd0, 16'd0, 6'd32));

    // Random part across register settings and flow-control mixes.
    run_phase(6'd0,  16'hFFFF, 16'hFFFF, 30, 54, 1'b1, 280);
    run_phase(6'd32, 16'd1920, 16'd1080, 30, 54, 1'b0, 280);
    run_phase(6'd16, 16'd0,    16'd0,    54, 30, 1'b0, 280);
    run_phase(6'd24, 16'hFFFF, 16'd4096, 54, 30, 1'b0, 280);
    run_phase(6'd0,  16'd800,  16'hFFFF, 0,  0,  1'b0, 280);
    run_phase(6'd32, 16'hFFFF, 16'hFFFF, 0,  0,  1'b0, 280);

    drain();
    repeat (TABLE_DEPTH + 10) @(posedge clk);
    if (sb.expected_q.size() != 0)
      $display("%0t: %0d results never arrived", $time, sb.expected_q.size());
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// File: display_mode_table_nearest_match.f
sv/dmt_pkg.sv
sv/dmt_ctrl.sv
sv/dmt_dp.sv
sv/display_mode_table_nearest_match.sv
tb/sv/testbench.sv
